/* hw/rtl/dbks_pkg.sv */
// Shared types and constants of the double-barrier knock-out smoothing core.
package dbks_pkg;

    localparam int DIV_BITS  = 32;
    localparam int COEF_LAT  = DIV_BITS + 7;
    localparam int BLEND_LAT = 3;

    localparam logic [2:0] CFG_LOW_BARRIER  = 3'd0;
    localparam logic [2:0] CFG_HIGH_BARRIER = 3'd1;
    localparam logic [2:0] CFG_TOLERANCE    = 3'd2;
    localparam logic [2:0] CFG_OUTSIDE_MODE = 3'd3;
    localparam logic [2:0] CFG_SMOOTHING_ON = 3'd4;
    localparam logic [2:0] CFG_KNOCK_DATE   = 3'd5;

    localparam logic [32:0] Y_ONE  = 33'h1_0000_0000;
    localparam logic [32:0] Y_HALF = 33'h0_8000_0000;
    localparam logic [35:0] T_FIFTEEN = 36'hF_0000_0000;

    typedef struct packed {
        logic below;
        logic over;
        logic eq;
        logic zero;
    } t_cflags;

endpackage

/* hw/rtl/dbks_coef.sv */
// Blend weight pipeline for one barrier: distance, restoring divider and smoothing polynomial.
module dbks_coef
    import dbks_pkg::*;
#(
    parameter int VALUE_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic signed [VALUE_WIDTH-1:0] i_idx,
    input  logic signed [VALUE_WIDTH-1:0] i_bar,
    input  logic        [VALUE_WIDTH-2:0] i_step,
    output logic        [32:0]            o_y,
    output logic                          o_direct,
    output logic                          o_below
);
    localparam int W  = VALUE_WIDTH;
    localparam int DW = W + 1;

    logic signed [DW-1:0] d_ib;
    logic signed [DW-1:0] d_bi;
    logic [DW-1:0]        r_mag;
    logic                 r_below0;
    logic [W-2:0]         r_step0;

    logic [W-1:0]  r_rem [0:DIV_BITS];
    logic [31:0]   r_q   [0:DIV_BITS];
    logic [W-2:0]  r_stp [0:DIV_BITS];
    t_cflags       r_fl  [0:DIV_BITS];

    logic [31:0]  r_a2_1, r_q1, r_a2_2, r_a4_2, r_q2, r_q3;
    logic [35:0]  r_t3;
    logic [67:0]  r_prod4;
    t_cflags      r_fl1, r_fl2, r_fl3, r_fl4;
    logic [63:0]  sq_a, sq_a2;
    logic [31:0]  p4;
    logic [32:0]  n_y;

    assign d_ib = DW'(i_idx) - DW'(i_bar);
    assign d_bi = DW'(i_bar) - DW'(i_idx);

    always_ff @(posedge i_clk) begin
        r_below0 <= d_ib[DW-1];
        r_mag    <= d_ib[DW-1] ? d_bi : d_ib;
        r_step0  <= i_step;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]      <= r_mag[W-1:0];
        r_q[0]        <= '0;
        r_stp[0]      <= r_step0;
        r_fl[0].below <= r_below0;
        r_fl[0].over  <= r_mag > DW'(r_step0);
        r_fl[0].eq    <= r_mag == DW'(r_step0);
        r_fl[0].zero  <= r_step0 == '0;
    end

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
        logic [DW-1:0] rem2;
        logic          ge;
        assign rem2 = {r_rem[i], 1'b0};
        assign ge   = rem2 >= DW'(r_stp[i]);
        always_ff @(posedge i_clk) begin
            r_rem[i+1] <= ge ? W'(rem2 - DW'(r_stp[i])) : W'(rem2);
            r_q[i+1]   <= {r_q[i][30:0], ge};
            r_stp[i+1] <= r_stp[i];
            r_fl[i+1]  <= r_fl[i];
        end
    end

    assign sq_a  = r_q[DIV_BITS] * r_q[DIV_BITS];
    assign sq_a2 = r_a2_1 * r_a2_1;
    assign p4    = r_prod4[67:36];

    always_ff @(posedge i_clk) begin
        r_a2_1  <= sq_a[63:32];
        r_q1    <= r_q[DIV_BITS];
        r_fl1   <= r_fl[DIV_BITS];
        r_a4_2  <= sq_a2[63:32];
        r_a2_2  <= r_a2_1;
        r_q2    <= r_q1;
        r_fl2   <= r_fl1;
        r_t3    <= T_FIFTEEN + 36'(r_a4_2) * 36'd3 - 36'(r_a2_2) * 36'd10;
        r_q3    <= r_q2;
        r_fl3   <= r_fl2;
        r_prod4 <= 68'(r_q3) * 68'(r_t3);
        r_fl4   <= r_fl3;
    end

    always_comb begin
        if (r_fl4.zero) begin
            n_y = Y_HALF;
        end else if (r_fl4.eq) begin
            n_y = r_fl4.below ? '0 : Y_ONE;
        end else if (r_fl4.below) begin
            n_y = Y_HALF - 33'(p4);
        end else begin
            n_y = Y_HALF + 33'(p4);
        end
    end

    always_ff @(posedge i_clk) begin
        o_y      <= n_y;
        o_direct <= r_fl4.over;
        o_below  <= r_fl4.below;
    end

endmodule

/* hw/rtl/dbks_blend.sv */
// Three-stage rounded convex blend of two values by a Q32 weight.
module dbks_blend
    import dbks_pkg::*;
#(
    parameter int VALUE_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic signed [VALUE_WIDTH-1:0] i_up,
    input  logic signed [VALUE_WIDTH-1:0] i_us_up,
    input  logic signed [VALUE_WIDTH-1:0] i_down,
    input  logic signed [VALUE_WIDTH-1:0] i_us_down,
    input  logic        [32:0]            i_y,
    input  logic                          i_direct,
    input  logic                          i_below,
    output logic signed [VALUE_WIDTH-1:0] o_res
);
    localparam int W  = VALUE_WIDTH;
    localparam int DW = W + 1;
    localparam int K  = DW / 2;
    localparam int HW = DW - K;
    localparam int AW = W + 35;

    logic signed [DW-1:0]   r_diff;
    logic signed [W-1:0]    r_base0, r_base1, r_dval0, r_dval1;
    logic [32:0]            r_y0;
    logic                   r_dir0, r_dir1;
    logic [K+32:0]          r_pl;
    logic signed [HW+33:0]  r_ph;
    logic signed [HW-1:0]   dh;
    logic signed [AW-1:0]   acc;

    always_ff @(posedge i_clk) begin
        r_diff  <= DW'(i_us_up) - DW'(i_us_down);
        r_base0 <= i_us_down;
        r_y0    <= i_y;
        r_dir0  <= i_direct;
        r_dval0 <= i_below ? i_down : i_up;
    end

    assign dh = r_diff[DW-1:K];

    always_ff @(posedge i_clk) begin
        r_pl    <= (K+33)'(r_diff[K-1:0]) * (K+33)'(r_y0);
        r_ph    <= (HW+34)'(dh) * $signed({1'b0, r_y0});
        r_base1 <= r_base0;
        r_dir1  <= r_dir0;
        r_dval1 <= r_dval0;
    end

    assign acc = (AW'(r_base1) <<< 32) + (AW'(r_ph) <<< K) + AW'({1'b0, r_pl})
               + AW'({1'b0, Y_HALF});

    always_ff @(posedge i_clk) begin
        o_res <= r_dir1 ? r_dval1 : acc[W+31:32];
    end

endmodule

/* hw/rtl/dbks_thresh.sv */
// Barrier thresholds widened and narrowed by the relative tolerance, and the consistency flag.
module dbks_thresh
    import dbks_pkg::*;
#(
    parameter int VALUE_WIDTH = 48
) (
    input  logic                            i_clk,
    input  logic signed [VALUE_WIDTH-1:0]   i_low,
    input  logic signed [VALUE_WIDTH-1:0]   i_high,
    input  logic        [31:0]              i_tol,
    output logic signed [VALUE_WIDTH+33:0]  o_lo_minus,
    output logic signed [VALUE_WIDTH+33:0]  o_lo_plus,
    output logic signed [VALUE_WIDTH+33:0]  o_hi_minus,
    output logic signed [VALUE_WIDTH+33:0]  o_hi_plus,
    output logic                            o_err
);
    localparam int W  = VALUE_WIDTH;
    localparam int K  = W / 2;
    localparam int HW = W - K;
    localparam int TW = W + 34;

    logic [K+31:0]          r_ll, r_hl;
    logic signed [HW+32:0]  r_lh, r_hh;
    logic signed [W-1:0]    r_low0, r_high0, r_low1, r_high1;
    logic signed [TW-1:0]   r_ltol, r_htol, r_lbase;
    logic signed [TW-1:0]   base_l, base_h;

    always_ff @(posedge i_clk) begin
        r_ll    <= (K+32)'(i_low[K-1:0]) * (K+32)'(i_tol);
        r_hl    <= (K+32)'(i_high[K-1:0]) * (K+32)'(i_tol);
        r_lh    <= (HW+33)'($signed(i_low[W-1:K])) * $signed({1'b0, i_tol});
        r_hh    <= (HW+33)'($signed(i_high[W-1:K])) * $signed({1'b0, i_tol});
        r_low0  <= i_low;
        r_high0 <= i_high;
    end

    always_ff @(posedge i_clk) begin
        r_ltol  <= (TW'(r_lh) <<< K) + TW'({1'b0, r_ll});
        r_htol  <= (TW'(r_hh) <<< K) + TW'({1'b0, r_hl});
        r_low1  <= r_low0;
        r_high1 <= r_high0;
    end

    assign base_l = TW'(r_low1) <<< 32;
    assign base_h = TW'(r_high1) <<< 32;

    always_ff @(posedge i_clk) begin
        o_lo_minus <= base_l - r_ltol;
        o_lo_plus  <= base_l + r_ltol;
        o_hi_minus <= base_h - r_htol;
        o_hi_plus  <= base_h + r_htol;
        r_lbase    <= base_l;
    end

    always_ff @(posedge i_clk) begin
        o_err <= r_lbase > o_hi_minus;
    end

endmodule

/* hw/rtl/double_barrier_knock_smoothing_core.sv */
// Top level of the double-barrier knock-out core with polynomial smoothing.
//
// One lattice node enters per beat: a node is taken at a rising edge with start
// high and busy low, and its five fields are sampled at that edge. The
// configuration port writes barriers, tolerance and the mode bits at any edge
// with i_cfg_we high; the user must see that it is written only while no node
// is in flight, as the block itself does not enforce this. Each node gives
// exactly one result, shown for one cycle with o_done high. A new node may
// enter in every cycle, so the sustained rate is one node per cycle. Each node
// passes through the two 32-stage restoring dividers that form the ratio of
// barrier distance to step, then the polynomial and two chained three-stage blends.
// Busy is high only during and in the cycle after reset. Synchronous reset
// clears the configuration and all valid bits in the pipeline, so nothing in
// flight is delivered. The receiver cannot hold results off and the pipeline
// never stalls. Configuration takes effect for nodes started in the next cycle.
module double_barrier_knock_smoothing_core
    import dbks_pkg::*;
#(
    parameter int VALUE_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] i_index_value,
    input  logic        [VALUE_WIDTH-2:0] i_index_step,
    input  logic signed [VALUE_WIDTH-1:0] i_rebate,
    input  logic signed [VALUE_WIDTH-1:0] i_smooth_in,
    input  logic signed [VALUE_WIDTH-1:0] i_plain_in,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32)-1:0] i_cfg_data,
    output logic                          o_done,
    output logic signed [VALUE_WIDTH-1:0] o_smooth_out,
    output logic signed [VALUE_WIDTH-1:0] o_plain_out,
    output logic                          o_barrier_error
);
    localparam int W  = VALUE_WIDTH;
    localparam int TW = W + 34;
    localparam int CL = COEF_LAT;
    localparam int BL = BLEND_LAT;
    localparam int D  = CL + 2 * BL;

    logic signed [W-1:0] r_low, r_high;
    logic [31:0]         r_tol;
    logic                r_outside, r_smooth_on, r_date, r_init;

    logic                r_v   [0:D];
    logic signed [W-1:0] r_idx [0:D];
    logic signed [W-1:0] r_reb [0:D];
    logic signed [W-1:0] r_sv  [0:D];
    logic signed [W-1:0] r_pv  [0:D];
    logic [W-2:0]        r_step;

    logic [32:0]         lo_y, hi_y;
    logic                lo_dir, lo_below, hi_dir, hi_below;
    logic [32:0]         r_hy   [0:BL-1];
    logic                r_hdir [0:BL-1];
    logic                r_hbel [0:BL-1];

    logic signed [W-1:0] l_up, l_us_up, l_down, l_us_down, x_res;
    logic signed [W-1:0] h_up, h_us_up, h_us_down, h_res;

    logic signed [TW-1:0] lo_minus, lo_plus, hi_minus, hi_plus, iw;
    logic                 th_err, knocked, accept;
    logic signed [W-1:0]  n_sv, n_pv;
    logic                 n_err;

    assign busy   = ~r_init;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= '0;
            r_high      <= '0;
            r_tol       <= '0;
            r_outside   <= 1'b0;
            r_smooth_on <= 1'b0;
            r_date      <= 1'b0;
            r_init      <= 1'b0;
        end else begin
            r_init <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LOW_BARRIER:  r_low       <= i_cfg_data[W-1:0];
                    CFG_HIGH_BARRIER: r_high      <= i_cfg_data[W-1:0];
                    CFG_TOLERANCE:    r_tol       <= i_cfg_data[31:0];
                    CFG_OUTSIDE_MODE: r_outside   <= i_cfg_data[0];
                    CFG_SMOOTHING_ON: r_smooth_on <= i_cfg_data[0];
                    CFG_KNOCK_DATE:   r_date      <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= D; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= accept;
            for (int k = 0; k < D; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx[0] <= i_index_value;
        r_reb[0] <= i_rebate;
        r_sv[0]  <= i_smooth_in;
        r_pv[0]  <= i_plain_in;
        r_step   <= i_index_step;
        for (int k = 0; k < D; k++) begin
            r_idx[k+1] <= r_idx[k];
            r_reb[k+1] <= r_reb[k];
            r_sv[k+1]  <= r_sv[k];
            r_pv[k+1]  <= r_pv[k];
        end
    end

    dbks_coef #(.VALUE_WIDTH(W)) u_coef_lo (
        .i_clk    (i_clk),
        .i_idx    (r_idx[0]),
        .i_bar    (r_low),
        .i_step   (r_step),
        .o_y      (lo_y),
        .o_direct (lo_dir),
        .o_below  (lo_below)
    );

    dbks_coef #(.VALUE_WIDTH(W)) u_coef_hi (
        .i_clk    (i_clk),
        .i_idx    (r_idx[0]),
        .i_bar    (r_high),
        .i_step   (r_step),
        .o_y      (hi_y),
        .o_direct (hi_dir),
        .o_below  (hi_below)
    );

    always_ff @(posedge i_clk) begin
        r_hy[0]   <= hi_y;
        r_hdir[0] <= hi_dir;
        r_hbel[0] <= hi_below;
        for (int k = 0; k < BL - 1; k++) begin
            r_hy[k+1]   <= r_hy[k];
            r_hdir[k+1] <= r_hdir[k];
            r_hbel[k+1] <= r_hbel[k];
        end
    end

    always_comb begin
        if (r_outside) begin
            l_up      = r_sv[CL];
            l_us_up   = r_pv[CL];
            l_down    = r_reb[CL];
            l_us_down = r_reb[CL];
            h_up      = r_reb[CL+BL];
            h_us_up   = r_reb[CL+BL];
            h_us_down = r_pv[CL+BL];
        end else begin
            l_up      = r_reb[CL];
            l_us_up   = r_reb[CL];
            l_down    = r_sv[CL];
            l_us_down = r_pv[CL];
            h_up      = r_sv[CL+BL];
            h_us_up   = r_pv[CL+BL];
            h_us_down = x_res;
        end
    end

    dbks_blend #(.VALUE_WIDTH(W)) u_blend_lo (
        .i_clk     (i_clk),
        .i_up      (l_up),
        .i_us_up   (l_us_up),
        .i_down    (l_down),
        .i_us_down (l_us_down),
        .i_y       (lo_y),
        .i_direct  (lo_dir),
        .i_below   (lo_below),
        .o_res     (x_res)
    );

    dbks_blend #(.VALUE_WIDTH(W)) u_blend_hi (
        .i_clk     (i_clk),
        .i_up      (h_up),
        .i_us_up   (h_us_up),
        .i_down    (x_res),
        .i_us_down (h_us_down),
        .i_y       (r_hy[BL-1]),
        .i_direct  (r_hdir[BL-1]),
        .i_below   (r_hbel[BL-1]),
        .o_res     (h_res)
    );

    dbks_thresh #(.VALUE_WIDTH(W)) u_thresh (
        .i_clk      (i_clk),
        .i_low      (r_low),
        .i_high     (r_high),
        .i_tol      (r_tol),
        .o_lo_minus (lo_minus),
        .o_lo_plus  (lo_plus),
        .o_hi_minus (hi_minus),
        .o_hi_plus  (hi_plus),
        .o_err      (th_err)
    );

    assign iw = TW'(r_idx[D]) <<< 32;

    always_comb begin
        if (r_outside) begin
            knocked = (iw < lo_plus) || (iw > hi_minus);
        end else begin
            knocked = (iw > lo_minus) && (iw < hi_plus);
        end
        n_sv  = r_sv[D];
        n_pv  = r_pv[D];
        n_err = 1'b0;
        if (r_date) begin
            if (th_err) begin
                n_err = 1'b1;
            end else if (r_smooth_on) begin
                n_sv = h_res;
                if (knocked) begin
                    n_pv = r_reb[D];
                end
            end else if (knocked) begin
                n_sv = r_reb[D];
                n_pv = r_reb[D];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done          <= 1'b0;
            o_barrier_error <= 1'b0;
        end else begin
            o_done          <= r_v[D];
            o_barrier_error <= r_v[D] & n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        o_smooth_out <= n_sv;
        o_plain_out  <= n_pv;
    end

endmodule

/* hw/rtl/dbks_checker.sv */
// Port-level assertions for the knock-out core and the bind that attaches them.
module dbks_checker
    import dbks_pkg::*;
#(
    parameter int VALUE_WIDTH = 48
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [VALUE_WIDTH-1:0] i_smooth_in,
    input logic signed [VALUE_WIDTH-1:0] i_plain_in,
    input logic                          o_done,
    input logic signed [VALUE_WIDTH-1:0] o_smooth_out,
    input logic signed [VALUE_WIDTH-1:0] o_plain_out,
    input logic                          o_barrier_error
);
    localparam int LAT = COEF_LAT + 2 * BLEND_LAT + 2;

    a_done_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("Result strobe without a matching input beat.");

    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_barrier_error |-> o_done)
        else $error("Barrier error raised outside a result.");

    a_err_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_barrier_error |-> (o_plain_out == $past(i_plain_in, LAT)
                             && o_smooth_out == $past(i_smooth_in, LAT)))
        else $error("Values not passed through on inconsistent barriers.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && busy)
        else $error("Result or ready seen right after reset.");

endmodule

bind double_barrier_knock_smoothing_core dbks_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_dbks_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_smooth_in     (i_smooth_in),
    .i_plain_in      (i_plain_in),
    .o_done          (o_done),
    .o_smooth_out    (o_smooth_out),
    .o_plain_out     (o_plain_out),
    .o_barrier_error (o_barrier_error)
);

/* tb/tb.sv */
// Testbench for the double-barrier knock-out smoothing core: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
    import dbks_pkg::*;

    localparam int VW = 48;
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam logic signed [VW-1:0] Q_ONE = 48'sh0001_0000_0000;
    localparam logic [VW-2:0]        S_ONE = 47'h0001_0000_0000;
    localparam logic signed [VW-1:0] V_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VW-1:0] V_MIN = 48'sh8000_0000_0000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [VW-1:0] index_value;
        logic [VW-2:0]        index_step;
        logic signed [VW-1:0] rebate;
        logic signed [VW-1:0] smooth_in;
        logic signed [VW-1:0] plain_in;
    } node_t;

    typedef struct {
        logic signed [VW-1:0] smooth_out;
        logic signed [VW-1:0] plain_out;
        logic                 barrier_error;
    } node_result_t;

    typedef struct {
        int           setting;
        node_t        node;
        bit           typed;
        node_result_t want;
    } vector_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [VW-1:0] i_index_value = '0;
    logic [VW-2:0]        i_index_step = '0;
    logic signed [VW-1:0] i_rebate = '0;
    logic signed [VW-1:0] i_smooth_in = '0;
    logic signed [VW-1:0] i_plain_in = '0;
    logic                 i_cfg_we = 1'b0;
    logic [2:0]           i_cfg_idx = '0;
    logic [VW-1:0]        i_cfg_data = '0;
    logic                 o_done;
    logic signed [VW-1:0] o_smooth_out;
    logic signed [VW-1:0] o_plain_out;
    logic                 o_barrier_error;

    logic signed [VW-1:0] bar_low;
    logic signed [VW-1:0] bar_high;
    logic [31:0]          bar_tol;
    logic                 mode_outside;
    logic                 mode_smooth;
    logic                 mode_date;

    node_result_t pending_results[$];
    int failures = 0;
    int nodes_sent = 0;
    int results_seen = 0;
    int knock_errors_seen = 0;
    int idle_cycles = 0;

    double_barrier_knock_smoothing_core #(.VALUE_WIDTH(VW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_index_value(i_index_value), .i_index_step(i_index_step),
        .i_rebate(i_rebate), .i_smooth_in(i_smooth_in), .i_plain_in(i_plain_in),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_smooth_out(o_smooth_out), .o_plain_out(o_plain_out),
        .o_barrier_error(o_barrier_error)
    );

    always #1 i_clk = ~i_clk;

    function automatic wide_t smooth_blend(wide_t up, wide_t us_up, wide_t down,
                                           wide_t us_down, wide_t idx, wide_t bar,
                                           wide_t step);
        wide_t one;
        wide_t half;
        wide_t mag;
        wide_t a;
        wide_t a2;
        wide_t a4;
        wide_t t;
        wide_t p;
        wide_t y;
        wide_t acc;
        logic below;
        one = wide_t'(1) <<< 32;
        half = wide_t'(1) <<< 31;
        below = idx < bar;
        mag = below ? bar - idx : idx - bar;
        if (mag > step) return below ? down : up;
        if (step == 0) a = 0;
        else if (mag == step) a = one;
        else a = (mag <<< 32) / step;
        if (a >= one) begin
            p = half;
        end else begin
            a2 = (a * a) >>> 32;
            a4 = (a2 * a2) >>> 32;
            t = 15 * one + 3 * a4 - 10 * a2;
            p = (a * t) >>> 36;
        end
        y = below ? half - p : half + p;
        acc = us_down * (one - y) + us_up * y + half;
        return acc >>> 32;
    endfunction

    function automatic int scaled_cmp(wide_t idx, wide_t bar, bit plus);
        wide_t lhs;
        wide_t f;
        wide_t rhs;
        f = plus ? (wide_t'(1) <<< 32) + wide_t'({1'b0, bar_tol})
                 : (wide_t'(1) <<< 32) - wide_t'({1'b0, bar_tol});
        lhs = idx <<< 32;
        rhs = bar * f;
        return (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
    endfunction

    function automatic node_result_t knockout_value(node_t n);
        node_result_t r;
        wide_t idx;
        wide_t step;
        wide_t reb;
        wide_t sv;
        wide_t pv;
        wide_t lo;
        wide_t hi;
        wide_t mid;
        logic knocked;
        idx = n.index_value;
        step = wide_t'({1'b0, n.index_step});
        reb = n.rebate;
        sv = n.smooth_in;
        pv = n.plain_in;
        lo = bar_low;
        hi = bar_high;
        r.barrier_error = 1'b0;
        if (mode_date) begin
            if (scaled_cmp(lo, hi, 1'b0) > 0) begin
                r.barrier_error = 1'b1;
            end else begin
                if (mode_outside)
                    knocked = scaled_cmp(idx, lo, 1'b1) < 0 || scaled_cmp(idx, hi, 1'b0) > 0;
                else
                    knocked = scaled_cmp(idx, lo, 1'b0) > 0 && scaled_cmp(idx, hi, 1'b1) < 0;
                if (mode_smooth) begin
                    if (mode_outside) begin
                        mid = smooth_blend(sv, pv, reb, reb, idx, lo, step);
                        sv = smooth_blend(reb, reb, mid, pv, idx, hi, step);
                    end else begin
                        mid = smooth_blend(reb, reb, sv, pv, idx, lo, step);
                        sv = smooth_blend(sv, pv, mid, mid, idx, hi, step);
                    end
                    if (knocked) pv = reb;
                end else if (knocked) begin
                    sv = reb;
                    pv = reb;
                end
            end
        end
        r.smooth_out = sv[VW-1:0];
        r.plain_out = pv[VW-1:0];
        return r;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [VW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LOW_BARRIER:  bar_low = data;
            CFG_HIGH_BARRIER: bar_high = data;
            CFG_TOLERANCE:    bar_tol = data[31:0];
            CFG_OUTSIDE_MODE: mode_outside = data[0];
            CFG_SMOOTHING_ON: mode_smooth = data[0];
            CFG_KNOCK_DATE:   mode_date = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_all(logic [VW-1:0] lo, logic [VW-1:0] hi, logic [VW-1:0] tol,
                           logic [VW-1:0] outside, logic [VW-1:0] smooth,
                           logic [VW-1:0] date);
        cfg_write(CFG_LOW_BARRIER, lo);
        cfg_write(CFG_HIGH_BARRIER, hi);
        cfg_write(CFG_TOLERANCE, tol);
        cfg_write(CFG_OUTSIDE_MODE, outside);
        cfg_write(CFG_SMOOTHING_ON, smooth);
        cfg_write(CFG_KNOCK_DATE, date);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_node(node_t n, int gap, bit typed, node_result_t want);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_index_value <= n.index_value;
        i_index_step <= n.index_step;
        i_rebate <= n.rebate;
        i_smooth_in <= n.smooth_in;
        i_plain_in <= n.plain_in;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        pending_results.push_back(typed ? want : knockout_value(n));
        nodes_sent++;
    endtask

    function automatic logic [VW-1:0] rand_value();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic signed [VW-1:0] rand_level();
        logic signed [VW-1:0] v;
        v = 48'(signed'($urandom));
        return v <<< $urandom_range(0, 8);
    endfunction

    function automatic int rand_gap(bit steady);
        if (steady) return 0;
        if ($urandom_range(0, 11) == 0) return $urandom_range(5, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic node_t rand_node();
        node_t n;
        wide_t base;
        wide_t off;
        n.rebate = rand_value();
        n.smooth_in = rand_value();
        n.plain_in = rand_value();
        if ($urandom_range(0, 7) == 0) begin
            n.index_value = rand_value();
            n.index_step = 47'(rand_value());
            return n;
        end
        case ($urandom_range(0, 5))
            0: n.index_step = '0;
            1: n.index_step = 47'($urandom) << $urandom_range(8, 14);
            default: n.index_step = 47'($urandom) >> $urandom_range(0, 4);
        endcase
        base = ($urandom_range(0, 1) != 0) ? wide_t'(bar_low) : wide_t'(bar_high);
        case ($urandom_range(0, 5))
            0: off = 0;
            1: off = wide_t'({1'b0, n.index_step});
            default: off = (wide_t'({1'b0, n.index_step}) * $urandom_range(0, 2000)) / 1000;
        endcase
        if ($urandom_range(0, 1) != 0) off = -off;
        base = base + off;
        n.index_value = base[VW-1:0];
        return n;
    endfunction

    task automatic apply_setting(int setting);
        case (setting)
            0: ;
            1: set_all(2 * Q_ONE, Q_ONE, 0, 0, 0, 1);
            2: begin
                set_all(-Q_ONE, Q_ONE, 0, 0, 0, 1);
                cfg_write(CFG_UNUSED, '1);
            end
            3: cfg_write(CFG_SMOOTHING_ON, 1);
            4: set_all(-Q_ONE, Q_ONE, 48'h8000_0000, 1, 1, 1);
            5: set_all(V_MIN, V_MAX, 48'hFFFF_FFFF, 1, 1, 1);
            6: set_all(V_MIN, V_MAX, 48'hFFFF_FFFF, 0, 1, 1);
            default: ;
        endcase
    endtask

    function automatic vector_t vec(int setting, logic signed [VW-1:0] idx,
                                    logic [VW-2:0] step, logic signed [VW-1:0] reb,
                                    logic signed [VW-1:0] sv, logic signed [VW-1:0] pv,
                                    bit typed = 0, logic signed [VW-1:0] ws = 0,
                                    logic signed [VW-1:0] wp = 0, logic we = 0);
        vector_t v;
        v.setting = setting;
        v.node = '{idx, step, reb, sv, pv};
        v.typed = typed;
        v.want = '{ws, wp, we};
        return v;
    endfunction

    always @(posedge i_clk) begin
        node_result_t w;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (o_barrier_error) knock_errors_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no node outstanding");
                failures++;
            end else begin
                w = pending_results.pop_front();
                if (o_smooth_out !== w.smooth_out) begin
                    $error("smooth_out: expected %0d, got %0d", w.smooth_out, o_smooth_out);
                    failures++;
                end
                if (o_plain_out !== w.plain_out) begin
                    $error("plain_out: expected %0d, got %0d", w.plain_out, o_plain_out);
                    failures++;
                end
                if (o_barrier_error !== w.barrier_error) begin
                    $error("barrier_error: expected %0b, got %0b", w.barrier_error,
                           o_barrier_error);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        vector_t table_rows[$];
        node_result_t none;
        int cur;
        bit steady;
        none = '{0, 0, 0};
        bar_low = 0;
        bar_high = 0;
        bar_tol = 0;
        mode_outside = 0;
        mode_smooth = 0;
        mode_date = 0;

        table_rows.push_back(vec(0, V_MAX, '1, V_MIN, V_MAX, V_MIN, 1, V_MAX, V_MIN, 0));
        table_rows.push_back(vec(0, V_MIN, '0, V_MAX, V_MIN, V_MAX, 1, V_MIN, V_MAX, 0));
        table_rows.push_back(vec(1, 0, S_ONE, 5, 7, 9, 1, 7, 9, 1));
        table_rows.push_back(vec(1, V_MIN, '1, V_MAX, V_MIN, V_MAX, 1, V_MIN, V_MAX, 1));
        table_rows.push_back(vec(2, 0, 0, 5, 7, 9, 1, 5, 5, 0));
        table_rows.push_back(vec(2, 5 * Q_ONE, 0, 5, 7, 9, 1, 7, 9, 0));
        table_rows.push_back(vec(2, -Q_ONE, 0, 5, 7, 9, 1, 7, 9, 0));
        table_rows.push_back(vec(3, -Q_ONE, 0, 100, 700, 900));
        table_rows.push_back(vec(3, 0, S_ONE, 100, 700, 900));
        table_rows.push_back(vec(3, Q_ONE / 2, S_ONE / 4, -100, 700, -900));
        table_rows.push_back(vec(3, -Q_ONE / 3, S_ONE, V_MAX, V_MIN, V_MAX));
        table_rows.push_back(vec(3, V_MAX, '1, V_MIN, V_MAX, V_MIN));
        table_rows.push_back(vec(4, -Q_ONE, 0, 100, 700, 900));
        table_rows.push_back(vec(4, Q_ONE, S_ONE / 2, 100, -700, 900));
        table_rows.push_back(vec(4, 2 * Q_ONE, S_ONE, V_MIN, V_MAX, V_MIN));
        table_rows.push_back(vec(4, 0, 47'h7FFF_FFFF_FFFF, 3, 5, 7));
        table_rows.push_back(vec(5, V_MAX, '1, V_MIN, V_MAX, V_MIN));
        table_rows.push_back(vec(5, V_MIN, 0, V_MAX, V_MIN, V_MAX));
        table_rows.push_back(vec(5, 0, '1, -1, 1, -1));
        table_rows.push_back(vec(6, V_MAX, 0, V_MIN, V_MAX, V_MIN));
        table_rows.push_back(vec(6, 0, 12345, V_MAX, V_MAX, V_MIN));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur = 0;
        foreach (table_rows[k]) begin
            if (table_rows[k].setting != cur) begin
                wait_idle();
                cur = table_rows[k].setting;
                apply_setting(cur);
            end
            send_node(table_rows[k].node, 0, table_rows[k].typed, table_rows[k].want);
        end

        for (int ph = 0; ph < 8; ph++) begin
            logic signed [VW-1:0] lo;
            logic signed [VW-1:0] hi;
            wait_idle();
            lo = rand_level();
            hi = lo + (rand_level() & V_MAX);
            if ($urandom_range(0, 5) == 0) {lo, hi} = {hi + 1, lo};
            set_all(lo, hi, 48'(($urandom_range(0, 3) == 0) ? $urandom : ($urandom >> 20)),
                    48'(ph[0]), 48'((ph % 4) != 3), 48'(ph != 5));
            steady = (ph == 2);
            repeat (150) send_node(rand_node(), rand_gap(steady), 1'b0, none);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            failures++;
        end
        $display("Sent %0d nodes over directed rows and 8 random settings;", nodes_sent);
        $display("checked %0d results, %0d with barrier error, %0d mismatches.",
                 results_seen, knock_errors_seen, failures);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
hw/rtl/dbks_pkg.sv
hw/rtl/dbks_coef.sv
hw/rtl/dbks_blend.sv
hw/rtl/dbks_thresh.sv
hw/rtl/double_barrier_knock_smoothing_core.sv
hw/rtl/dbks_checker.sv
tb/tb.sv
